FILE: src/finite_difference_derivative_top_macros.svh
// Assertion macros shared by the finite-difference derivative checker.
`ifndef FINITE_DIFFERENCE_DERIVATIVE_TOP_MACROS_SVH
`define FINITE_DIFFERENCE_DERIVATIVE_TOP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define FDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define FDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fdd_pkg.sv
// Shared types and constants for the finite-difference derivative block.
`default_nettype none

package fdd_pkg;

  localparam int IN_W    = 32;  // width of one input coordinate field
  localparam int OUT_W   = 48;  // width of one output derivative field
  localparam int GAIN_W  = 32;  // Q16.16 gain register width
  localparam int FRAC_W  = 16;  // fractional bits of the gain
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 3;   // frame count and result count width
  localparam int HIST_D  = 4;   // frames kept in the history

  localparam logic [CNT_W-1:0] CNT_MAX = 3'd5;

  // Configuration register indexes.
  localparam logic REG_STENCIL_MODE = 1'b0;
  localparam logic REG_RATE_GAIN    = 1'b1;

  // Stencil mode codes; the unused code behaves as the five-point stencil.
  localparam logic [MODE_W-1:0] MODE_FIVE_POINT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACKWARD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CENTRAL    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

  // Per-item control carried alongside the data through the pipeline.
  typedef struct packed {
    logic [CNT_W-1:0] count;  // number of result items to emit
    logic             last;   // item closes the stream
  } fdd_ctl_t;

endpackage

`default_nettype wire

FILE: src/fdd_front.sv
// Front stage: sample history, frame count, stencil difference and result count.
`default_nettype none

module fdd_front #(
  parameter int COORDS      = 3,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    accept,
  input  wire logic                                    en,
  input  wire logic [COORDS*fdd_pkg::IN_W-1:0]         pos,
  input  wire logic                                    last_in,
  input  wire logic [fdd_pkg::MODE_W-1:0]              mode,
  output logic                                         valid,
  output fdd_pkg::fdd_ctl_t                            ctl,
  output logic signed [COORDS-1:0][SAMPLE_BITS+4:0]    diff
);
  import fdd_pkg::*;

  localparam int DW = SAMPLE_BITS + 5;

  logic [SAMPLE_BITS-1:0] hist [HIST_D][COORDS];
  logic [CNT_W-1:0]       frame_count;

  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  first;
  logic [CNT_W-1:0]  tail;
  logic              short_run;
  logic [CNT_W-1:0]  count_next;
  logic signed [COORDS-1:0][DW-1:0] diff_next;

  always_comb begin
    case (mode)
      MODE_BACKWARD: begin
        need = 3'd1; first = 3'd2; tail = 3'd0;
      end
      MODE_CENTRAL: begin
        need = 3'd2; first = 3'd2; tail = 3'd1;
      end
      default: begin
        need = 3'd4; first = 3'd3; tail = 3'd2;
      end
    endcase
  end

  assign short_run = frame_count < need;

  always_comb begin
    if (short_run) begin
      count_next = last_in ? frame_count + 3'd1 : 3'd0;
    end else begin
      count_next = ((frame_count == need) ? first : 3'd1) + (last_in ? tail : 3'd0);
    end
  end

  for (genvar c = 0; c < COORDS; c++) begin : g_coord
    logic [SAMPLE_BITS-1:0] cur;
    logic signed [DW-1:0]   e_cur, e_h0, e_h1, e_h2, e_h3;

    assign cur   = pos[c*IN_W +: SAMPLE_BITS];
    assign e_cur = {{5{cur[SAMPLE_BITS-1]}}, cur};
    assign e_h0  = {{5{hist[0][c][SAMPLE_BITS-1]}}, hist[0][c]};
    assign e_h1  = {{5{hist[1][c][SAMPLE_BITS-1]}}, hist[1][c]};
    assign e_h2  = {{5{hist[2][c][SAMPLE_BITS-1]}}, hist[2][c]};
    assign e_h3  = {{5{hist[3][c][SAMPLE_BITS-1]}}, hist[3][c]};

    always_comb begin
      if (short_run) begin
        diff_next[c] = '0;
      end else begin
        case (mode)
          MODE_BACKWARD: diff_next[c] = e_cur - e_h0;
          MODE_CENTRAL:  diff_next[c] = e_cur - e_h1;
          default:       diff_next[c] = e_h3 - (e_h2 <<< 3) + (e_h0 <<< 3) - e_cur;
        endcase
      end
    end
  end

  // History and frame count move only when an item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      for (int i = 0; i < HIST_D; i++) begin
        for (int c = 0; c < COORDS; c++) begin
          hist[i][c] <= '0;
        end
      end
    end else if (accept) begin
      if (last_in) begin
        frame_count <= '0;
      end else begin
        for (int c = 0; c < COORDS; c++) begin
          hist[0][c] <= pos[c*IN_W +: SAMPLE_BITS];
          for (int i = 1; i < HIST_D; i++) begin
            hist[i][c] <= hist[i-1][c];
          end
        end
        if (frame_count < CNT_MAX) begin
          frame_count <= frame_count + 3'd1;
        end
      end
    end
  end

  // Items that produce no result are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= accept && (count_next != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.count <= count_next;
      ctl.last  <= last_in;
      diff      <= diff_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/fdd_scale.sv
// Gain stage for one coordinate: Q16.16 multiply, rounding and 48-bit saturation.
`default_nettype none

module fdd_scale #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              en_mul,
  input  wire logic                              en_out,
  input  wire logic signed [SAMPLE_BITS+4:0]     diff,
  input  wire logic [fdd_pkg::GAIN_W-1:0]        gain,
  output logic [fdd_pkg::OUT_W-1:0]              rate
);
  import fdd_pkg::*;

  localparam int DW = SAMPLE_BITS + 5;
  localparam int AW = DW - 1;            // magnitude width
  localparam int MW = AW + FRAC_W;       // product width
  localparam int SW = MW + 1;            // rounded sum width
  localparam int RW = (SW > OUT_W) ? SW : OUT_W;

  localparam logic [RW-1:0] POS_LIM = RW'(48'h7FFF_FFFF_FFFF);
  localparam logic [RW-1:0] NEG_LIM = RW'(48'h8000_0000_0000);

  logic [DW-1:0] diff_neg;
  logic [AW-1:0] mag;
  logic [MW-1:0] p_hi, p_lo;
  logic          neg;

  logic [MW-1:0]    lo_round;
  logic [SW-1:0]    sum;
  logic [RW-1:0]    sum_ext;
  logic [RW-1:0]    sat;
  logic [OUT_W-1:0] sat48;

  assign diff_neg = -diff;
  assign mag      = diff[DW-1] ? diff_neg[AW-1:0] : diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_hi <= MW'(mag) * MW'(gain[GAIN_W-1:FRAC_W]);
      p_lo <= MW'(mag) * MW'(gain[FRAC_W-1:0]);
      neg  <= diff[DW-1];
    end
  end

  // Round half away from zero on the magnitude, then clamp.
  assign lo_round = (p_lo + MW'(32'h8000)) >> FRAC_W;
  assign sum      = SW'(p_hi) + SW'(lo_round);
  assign sum_ext  = RW'(sum);

  always_comb begin
    if (neg) begin
      sat = (sum_ext > NEG_LIM) ? NEG_LIM : sum_ext;
    end else begin
      sat = (sum_ext > POS_LIM) ? POS_LIM : sum_ext;
    end
  end

  assign sat48 = sat[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (en_out) begin
      rate <= neg ? (OUT_W'(0) - sat48) : sat48;
    end
  end

endmodule

`default_nettype wire

FILE: src/finite_difference_derivative_top.sv
// Top level of the streaming finite-difference derivative block.
//
//   Channel   Direction  Handshake               Payload
//   s_*       in         s_tvalid / s_tready     s_tdata = coordinates, s_tlast = final sample
//   m_*       out        m_tvalid / m_tready     m_tdata = derivatives, m_tlast = end of run
//   cfg_*     in         cfg_we (no wait)        cfg_index selects register, cfg_data value
//
// One input item can be taken every cycle while s_tready is high. The first
// result of an item passes the difference register, the gain multiply register
// and then the output register before it is offered on the output. An item
// that yields several results (at the start of a stream or on its final frame)
// holds the output register until each of its results has been taken. Input
// stalls once both front stages hold items and the output register cannot
// load, either because a result waits on m_tready or because it is still
// repeating.
// Reset is synchronous and clears the history, frame count, configuration
// and all valid flags.
`default_nettype none

module finite_difference_derivative_top #(
  parameter int COORDS      = 3,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input items: pos_x, pos_y, pos_z, ... at 32 bits each from the lowest bit up.
  input  wire logic [COORDS*fdd_pkg::IN_W-1:0]    s_tdata,
  input  wire logic                               s_tlast,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // Result items: rate_x, rate_y, rate_z, ... at 48 bits each from the lowest bit up.
  output logic [COORDS*fdd_pkg::OUT_W-1:0]        m_tdata,
  output logic                                    m_tlast,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // Configuration writes.
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [fdd_pkg::GAIN_W-1:0]         cfg_data
);
  import fdd_pkg::*;

  localparam int DW = SAMPLE_BITS + 5;

  logic [MODE_W-1:0] stencil_mode;
  logic [GAIN_W-1:0] rate_gain;

  logic accept;
  logic en_front, en_mul, en_out;

  logic                             s1_valid;
  fdd_ctl_t                         s1_ctl;
  logic signed [COORDS-1:0][DW-1:0] s1_diff;

  logic     s2_valid;
  fdd_ctl_t s2_ctl;

  logic             out_valid;
  logic [CNT_W-1:0] out_cnt;
  logic             out_last;

  // Configuration registers: software must write only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      stencil_mode <= MODE_FIVE_POINT;
      rate_gain    <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STENCIL_MODE: stencil_mode <= cfg_data[MODE_W-1:0];
        REG_RATE_GAIN:    rate_gain    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // The output register is free when empty or when its last repeat is taken.
  // Each earlier stage moves when it is empty or the stage after it moves.
  assign en_out   = !out_valid || (m_tready && out_cnt == 3'd1);
  assign en_mul   = !s2_valid || en_out;
  assign en_front = !s1_valid || en_mul;
  assign s_tready = en_front;
  assign accept   = s_tvalid && s_tready;

  fdd_front #(
    .COORDS      (COORDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .en      (en_front),
    .pos     (s_tdata),
    .last_in (s_tlast),
    .mode    (stencil_mode),
    .valid   (s1_valid),
    .ctl     (s1_ctl),
    .diff    (s1_diff)
  );

  for (genvar c = 0; c < COORDS; c++) begin : g_scale
    fdd_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
      .clk    (clk),
      .en_mul (en_mul),
      .en_out (en_out),
      .diff   (s1_diff[c]),
      .gain   (rate_gain),
      .rate   (m_tdata[c*OUT_W +: OUT_W])
    );
  end

  // Control that travels beside the multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en_mul) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      s2_ctl <= s1_ctl;
    end
  end

  // Output register: repeats the same value out_cnt times; only the final
  // repeat of a stream's last frame carries end of run.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_cnt   <= '0;
      out_last  <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_valid;
      out_cnt   <= s2_ctl.count;
      out_last  <= s2_ctl.last;
    end else if (m_tready) begin
      out_cnt <= out_cnt - 3'd1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last && (out_cnt == 3'd1);

endmodule

`default_nettype wire

FILE: src/fdd_checker.sv
// Port-level assertions for the finite-difference derivative block, with its bind.
`default_nettype none

`include "finite_difference_derivative_top_macros.svh"

module fdd_checker #(
  parameter int COORDS = 3
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [COORDS*fdd_pkg::OUT_W-1:0] m_tdata,
  input wire logic                            m_tlast,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready
);

  // A result offered and not taken stays offered.
  `FDD_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

  // A stalled result keeps its payload.
  `FDD_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // Reset empties the output register.
  `FDD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result offered right after reset")

  // With the output register empty, every stage in front can move, so input is open.
  `FDD_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind finite_difference_derivative_top fdd_checker #(
  .COORDS (COORDS)
) u_fdd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the streaming finite-difference derivative block.
`timescale 1ns / 100ps

module tb_top;
  import fdd_pkg::*;

  localparam int NCOORD     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT = 8;   // three pipeline stages plus margin
  localparam bit [63:0] POS_SAT = (64'd1 << 47) - 64'd1;
  localparam bit [63:0] NEG_SAT = 64'd1 << 47;

  // One input item: three coordinates and the final-frame flag.
  typedef struct packed {
    bit [NCOORD-1:0][IN_W-1:0] pos;
    bit                        fin;
  } frame_t;

  // One result item: three derivatives and the end-of-run flag.
  typedef struct packed {
    bit [NCOORD-1:0][OUT_W-1:0] rate;
    bit                         eor;
  } rate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // s_tdata: pos_x, pos_y, pos_z from the lowest bit up.
  logic [NCOORD*IN_W-1:0]  s_tdata  = '0;
  logic                    s_tlast  = 1'b0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // m_tdata: rate_x, rate_y, rate_z from the lowest bit up.
  logic [NCOORD*OUT_W-1:0] m_tdata;
  logic                    m_tlast;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic                    cfg_index = 1'b0;
  logic [GAIN_W-1:0]       cfg_data  = '0;

  finite_difference_derivative_top #(
    .COORDS(NCOORD),
    .SAMPLE_BITS(IN_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be driven, and derivatives the block still owes us.
  frame_t frame_q[$];
  rate_t  rate_q[$];
  frame_t held_frame;
  int     err_count = 0;
  int     cycle_count = 0;
  bit     no_gaps = 1'b0;

  // Our own copy of the block's configuration and stream state.
  bit [MODE_W-1:0] cfg_mode = MODE_FIVE_POINT;
  bit [GAIN_W-1:0] cfg_gain = GAIN_RESET;
  longint          hist[HIST_D][NCOORD];
  int              frames_seen = 0;

  // A gap with a chance of 31 in a hundred, unless a gap-free stretch is running.
  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 31);
  endfunction

  // Q16.16 scaling with rounding half away from zero, then 48-bit saturation.
  function automatic bit [OUT_W-1:0] scale_rate(longint d);
    bit [63:0] mag;
    bit [63:0] gh;
    bit [63:0] gl;
    bit [63:0] r;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    gh  = {48'd0, cfg_gain[31:16]};
    gl  = {48'd0, cfg_gain[15:0]};
    r   = mag * gh + ((mag * gl + 64'h8000) >> 16);
    if (d < 0) begin
      if (r > NEG_SAT) r = NEG_SAT;
      r = -r;
      return r[OUT_W-1:0];
    end
    if (r > POS_SAT) r = POS_SAT;
    return r[OUT_W-1:0];
  endfunction

  // Works out the derivatives that one accepted frame causes and queues them.
  task automatic predict_derivatives(input frame_t f);
    longint cur[NCOORD];
    longint d;
    rate_t  r;
    int     need;
    int     first_n;
    int     tail_n;
    int     n;
    // The unused mode code falls back to the five-point stencil.
    case (cfg_mode)
      MODE_BACKWARD: begin
        need = 1; first_n = 2; tail_n = 0;
      end
      MODE_CENTRAL: begin
        need = 2; first_n = 2; tail_n = 1;
      end
      default: begin
        need = 4; first_n = 3; tail_n = 2;
      end
    endcase
    for (int c = 0; c < NCOORD; c++) cur[c] = longint'($signed(f.pos[c]));
    r = '0;
    n = 0;
    if (frames_seen < need) begin
      // Stream too short for the stencil: one zero result per frame seen.
      if (f.fin) n = frames_seen + 1;
    end else begin
      for (int c = 0; c < NCOORD; c++) begin
        case (cfg_mode)
          MODE_BACKWARD: d = cur[c] - hist[0][c];
          MODE_CENTRAL:  d = cur[c] - hist[1][c];
          default:       d = hist[3][c] - 8 * hist[2][c] + 8 * hist[0][c] - cur[c];
        endcase
        r.rate[c] = scale_rate(d);
      end
      // Leading edge repeats on the first full stencil, trailing edge on the last frame.
      n = (frames_seen == need) ? first_n : 1;
      if (f.fin) n += tail_n;
    end
    for (int i = 0; i < n; i++) begin
      r.eor = f.fin && (i == n - 1);
      rate_q.push_back(r);
    end
    if (f.fin) begin
      frames_seen = 0;
    end else begin
      for (int i = HIST_D - 1; i > 0; i--) hist[i] = hist[i-1];
      for (int c = 0; c < NCOORD; c++) hist[0][c] = cur[c];
      if (frames_seen < CNT_MAX) frames_seen++;
    end
  endtask

  // Driver: presents the next pending item once the current one is taken.
  // The accepted item is predicted at the same edge it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_derivatives(held_frame);
      if (!s_tvalid || s_tready) begin
        if (frame_q.size() != 0 && !take_gap()) begin
          held_frame = frame_q.pop_front();
          s_tdata  <= held_frame.pos;
          s_tlast  <= held_frame.fin;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation,
  // and applies random back-pressure on the output side.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rate_q.size() == 0) begin
          $error("unexpected result item rate_x=%0d end_of_run=%0b",
                 $signed(m_tdata[OUT_W-1:0]), m_tlast);
          err_count++;
        end else begin
          rate_t e;
          e = rate_q.pop_front();
          for (int c = 0; c < NCOORD; c++) begin
            if (m_tdata[c*OUT_W +: OUT_W] !== e.rate[c]) begin
              $error("rate_%s expected %0d actual %0d", (c == 0) ? "x" : (c == 1) ? "y" : "z",
                     $signed(e.rate[c]), $signed(m_tdata[c*OUT_W +: OUT_W]));
              err_count++;
            end
          end
          if (m_tlast !== e.eor) begin
            $error("end_of_run expected %0b actual %0b", e.eor, m_tlast);
            err_count++;
          end
        end
      end
      m_tready <= !take_gap();
    end
  end

  // Cycle counter; a run that hangs is ended here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Waits until every item is taken and every result has come back, then lets
  // the pipeline settle, since frames that cause no result may still be in it.
  task automatic wait_idle();
    @(negedge clk);
    while (frame_q.size() != 0 || s_tvalid || rate_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input bit [GAIN_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Both registers are rewritten only while the block is idle.
  task automatic set_config(input bit [MODE_W-1:0] mode, input bit [GAIN_W-1:0] gain);
    wait_idle();
    write_reg(REG_STENCIL_MODE, {{(GAIN_W-MODE_W){1'b0}}, mode});
    write_reg(REG_RATE_GAIN, gain);
    cfg_mode = mode;
    cfg_gain = gain;
  endtask

  task automatic push_frame(input bit [31:0] x, input bit [31:0] y, input bit [31:0] z,
                            input bit fin);
    frame_t f;
    f.pos[0] = x;
    f.pos[1] = y;
    f.pos[2] = z;
    f.fin    = fin;
    frame_q.push_back(f);
  endtask

  // Coordinate styles: full range, small values near zero, or extremes.
  function automatic bit [31:0] pick_coord(int style);
    case (style)
      0: return $urandom;
      1: return 32'($urandom_range(400)) - 32'd200;
      default: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic bit [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return GAIN_RESET;
      3: return $urandom;
      4: return $urandom_range(32'h0004_0000);
      default: return {16'($urandom_range(3)), 16'h8000};
    endcase
  endfunction

  // A phase of random streams. Most streams are closed by a final frame; some
  // are left open so the next phase continues them under its own configuration.
  task automatic random_phase(input bit [MODE_W-1:0] mode, input int n_items);
    int pushed;
    int len;
    int style;
    bit close;
    set_config(mode, pick_gain());
    pushed = 0;
    while (pushed < n_items) begin
      len   = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 12);
      style = ($urandom_range(9) < 4) ? 0 : ($urandom_range(9) < 7) ? 1 : 2;
      close = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++)
        push_frame(pick_coord(style), pick_coord(style), pick_coord(style),
                   close && (i == len - 1));
      pushed += len;
    end
  endtask

  initial begin : stimulus
    bit [MODE_W-1:0] mode;
    for (int i = 0; i < HIST_D; i++)
      for (int c = 0; c < NCOORD; c++) hist[i][c] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Five-point stencil at unit gain: a full stream through extreme values,
    // then a one-frame stream and a three-frame stream that never fill it.
    set_config(MODE_FIVE_POINT, GAIN_RESET);
    push_frame(32'h0, 32'h0, 32'h0, 1'b0);
    push_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0);
    push_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_frame(32'h1, 32'hFFFF_FFFF, 32'h0, 1'b0);
    push_frame(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0);
    push_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h2, 1'b1);
    push_frame(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 1'b1);
    push_frame(32'h5, 32'h6, 32'h7, 1'b0);
    push_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
    push_frame(32'h9, 32'hA, 32'hB, 1'b1);

    // Backward difference at the largest gain: saturation in both directions,
    // a zero difference, and a one-frame stream.
    set_config(MODE_BACKWARD, 32'hFFFF_FFFF);
    push_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
    push_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h5, 1'b0);
    push_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h5, 1'b0);
    push_frame(32'h0, 32'h0, 32'hFFFF_FFFB, 1'b1);
    push_frame(32'hFFFF_FFFF, 32'h1, 32'h0, 1'b1);

    // Central difference at half gain: odd differences land exactly on a
    // half and must round away from zero.
    set_config(MODE_CENTRAL, 32'h0000_8000);
    push_frame(32'h0, 32'h0, 32'h0, 1'b0);
    push_frame(32'h2, 32'h2, 32'h2, 1'b0);
    push_frame(32'h1, 32'hFFFF_FFFF, 32'h3, 1'b0);
    push_frame(32'h4, 32'h4, 32'h4, 1'b0);
    push_frame(32'hFFFF_FFFD, 32'h7, 32'h0, 1'b1);

    // The unused mode code acts as the five-point stencil; zero gain.
    set_config(MODE_UNUSED, 32'h0);
    for (int i = 0; i < 5; i++)
      push_frame($urandom, $urandom, $urandom, i == 4);

    // Random phases, one of them without any idle cycles on either side.
    for (int p = 0; p < 8; p++) begin
      mode = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(3));
      if (p == 5) begin
        wait_idle();
        no_gaps = 1'b1;
      end else if (p == 6) begin
        wait_idle();
        no_gaps = 1'b0;
      end
      random_phase(mode, 50);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
